### hdl/lifo_preemptive_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// lifo preemptive scheduler assertion macros
// concurrent check wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LIFO_PREEMPTIVE_SCHEDULER_CORE_MACROS_SVH
`define LIFO_PREEMPTIVE_SCHEDULER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LPS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LPS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define LPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lifo preemptive scheduler package
// widths, codes and beat types shared by the scheduler modules
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int STACK_DEPTH   = 16;
   localparam int TIME_BITS     = 32;
   localparam int COUNT_BITS    = $clog2(STACK_DEPTH + 1);
   localparam int INDEX_BITS    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int ID_BITS       = 8;
   localparam int BURST_BITS    = 16;
   localparam int KIND_BITS     = 2;
   localparam int OUT_TIME_BITS = 32;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   localparam logic MODE_ARRIVE = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ZERO = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DROP = 2'd2;

   localparam count_type FULL_COUNT = COUNT_BITS'(STACK_DEPTH);

   typedef struct packed {
      logic                  mode;
      logic [ID_BITS-1:0]    proc_id;
      logic [BURST_BITS-1:0] burst;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [ID_BITS-1:0]       proc_id_res;
      logic [OUT_TIME_BITS-1:0] turnaround_time;
      logic [OUT_TIME_BITS-1:0] wait_ticks;
   } rsp_type;

   // base = arrival - 1, wbase = arrival - 1 + burst, so that
   // turnaround = now - base and waiting = now - wbase
   typedef struct packed {
      logic [ID_BITS-1:0]    proc_id;
      logic [BURST_BITS-1:0] remaining;
      time_type              base;
      time_type              wbase;
   } entry_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      logic      dec;
      entry_type entry;
   } stack_op_type;

   typedef struct packed {
      count_type count;
      logic      empty;
      logic      full;
      entry_type top;
   } stack_status_type;

endpackage

### hdl/lps_stack.sv
// ----------------------------------------------------------------------------
// lps job stack
// entry storage with push at the fill level and pop/decrement at the top
// ----------------------------------------------------------------------------
module lps_stack (
   input  logic                     clock,
   input  logic                     reset,
   input  lps_pkg::stack_op_type    op,
   output lps_pkg::stack_status_type status
);

   lps_pkg::entry_type entry_ff [lps_pkg::STACK_DEPTH];
   lps_pkg::count_type count_ff;
   lps_pkg::count_type count_in;
   lps_pkg::index_type push_idx;
   lps_pkg::index_type top_idx;

   assign push_idx = count_ff[lps_pkg::INDEX_BITS-1:0];
   assign top_idx  = lps_pkg::INDEX_BITS'(count_ff - lps_pkg::COUNT_BITS'(1));

   always_comb begin
      count_in = count_ff;
      if (op.push) begin
         count_in = count_ff + lps_pkg::COUNT_BITS'(1);
      end else if (op.pop) begin
         count_in = count_ff - lps_pkg::COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entries carry no reset, only slots below the count are ever used
   always_ff @(posedge clock) begin
      if (op.push) begin
         entry_ff[push_idx] <= op.entry;
      end else if (op.dec) begin
         entry_ff[top_idx].remaining <=
            entry_ff[top_idx].remaining - lps_pkg::BURST_BITS'(1);
      end
   end

   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff >= lps_pkg::FULL_COUNT);
   assign status.top   = entry_ff[top_idx];

endmodule

### hdl/lps_sched.sv
// ----------------------------------------------------------------------------
// lps scheduling step
// decodes one registered beat against the stack top and registers the result
// ----------------------------------------------------------------------------
module lps_sched (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  lps_pkg::req_type          item,
   input  lps_pkg::stack_status_type status,
   output lps_pkg::stack_op_type     op,
   output logic                      rsp_strobe,
   output lps_pkg::rsp_type          rsp_data
);

   lps_pkg::time_type tick_ff;
   lps_pkg::time_type tick_in;
   lps_pkg::time_type tick_last_ff;
   lps_pkg::time_type tick_last_in;
   logic              strobe_ff;
   logic              strobe_in;
   lps_pkg::rsp_type  rsp_ff;
   lps_pkg::rsp_type  rsp_in;
   lps_pkg::time_type tat;
   lps_pkg::time_type wt;

   assign tat = tick_ff - status.top.base;
   assign wt  = tick_ff - status.top.wbase;

   always_comb begin
      op                   = '0;
      op.entry.proc_id     = item.proc_id;
      op.entry.remaining   = item.burst;
      op.entry.base        = tick_last_ff;
      op.entry.wbase       = tick_last_ff + lps_pkg::TIME_BITS'(item.burst);
      tick_in              = tick_ff;
      tick_last_in         = tick_last_ff;
      strobe_in            = 1'b0;
      rsp_in               = '0;
      rsp_in.proc_id_res   = item.proc_id;
      if (item_valid) begin
         if (item.mode == lps_pkg::MODE_ARRIVE) begin
            if (item.burst == '0) begin
               strobe_in   = 1'b1;
               rsp_in.kind = lps_pkg::KIND_ZERO;
            end else if (status.full) begin
               strobe_in   = 1'b1;
               rsp_in.kind = lps_pkg::KIND_DROP;
            end else begin
               op.push = 1'b1;
            end
         end else begin
            tick_in      = tick_ff + lps_pkg::TIME_BITS'(1);
            tick_last_in = tick_ff;
            if (!status.empty) begin
               // stored jobs never hold zero, so one left means it ends now
               if (status.top.remaining == lps_pkg::BURST_BITS'(1)) begin
                  op.pop                 = 1'b1;
                  strobe_in              = 1'b1;
                  rsp_in.kind            = lps_pkg::KIND_DONE;
                  rsp_in.proc_id_res     = status.top.proc_id;
                  rsp_in.turnaround_time = lps_pkg::OUT_TIME_BITS'(tat);
                  rsp_in.wait_ticks      = lps_pkg::OUT_TIME_BITS'(wt);
               end else begin
                  op.dec = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         tick_last_ff <= '1;
         strobe_ff    <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         tick_last_ff <= tick_last_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hdl/lifo_preemptive_scheduler_core.sv
// ----------------------------------------------------------------------------
// lifo preemptive scheduler core
// preemptive last-come-first-served job stack with turnaround reporting
// ----------------------------------------------------------------------------
// One beat is taken every clock: busy stays low, so start may be held high
// continuously. A beat goes through an input register and one step against
// the stack top, and any result shows on rsp_strobe/rsp_data from the first
// clock edge after the one that accepted it, for that single cycle only, so
// it is taken at the second edge: the receiver cannot stall and must capture
// it then. Arrivals and ticks each touch only the top of the job stack and
// the tick counter, which fixes the rate at one beat per clock. Stack
// entries have no reset; only the fill count is cleared.
`include "lifo_preemptive_scheduler_core_macros.svh"

module lifo_preemptive_scheduler_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lps_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lps_pkg::rsp_type rsp_data
);

   logic                      item_valid_ff;
   logic                      item_valid_in;
   lps_pkg::req_type          item_ff;
   lps_pkg::stack_op_type     op;
   lps_pkg::stack_status_type status;

   // every beat finishes in one step, nothing ever holds the input off
   assign busy          = 1'b0;
   assign item_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_in) begin
         item_ff <= req_data;
      end
   end

   lps_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .status (status)
   );

   lps_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .status     (status),
      .op         (op),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `LPS_ASSERT_IMPL(a_rsp_has_source, clock, reset, rsp_strobe,
      $past(item_valid_in, 2), "result beat without an accepted request")
   `LPS_ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1,
      status.count <= lps_pkg::FULL_COUNT, "stack count beyond depth")
   `LPS_ASSERT_IMPL(a_done_pops, clock, reset,
      rsp_strobe && (rsp_data.kind == lps_pkg::KIND_DONE),
      (status.count + lps_pkg::COUNT_BITS'(1)) == $past(status.count),
      "completion without a pop")
   `LPS_ASSERT_IMPL(a_drop_when_full, clock, reset,
      rsp_strobe && (rsp_data.kind == lps_pkg::KIND_DROP),
      $past(status.full) && status.full, "drop reported while stack had room")
   `LPS_ASSERT_NEXT(a_no_op_when_idle, clock, reset, !item_valid_in,
      !(op.push || op.pop || op.dec), "stack changed without a beat")

endmodule

### tb/sv/tb_lifo_preemptive_scheduler_core.sv
// ----------------------------------------------------------------------------
// lifo preemptive scheduler core testbench
// drives a short table of directed arrivals and ticks, then random traffic
// whose tick density changes from segment to segment, so that the job stack
// fills, overflows and drains again. every result is compared field by
// field with a typed table report or a predictor keeping its own job stack
// ----------------------------------------------------------------------------
module tb_lifo_preemptive_scheduler_core;

   localparam int RANDOM_BEATS = 1340;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_LIMIT  = 100;

   typedef struct packed {
      lps_pkg::req_type beat;
      logic             typed;
      lps_pkg::rsp_type report;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   lps_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   lps_pkg::rsp_type rsp_data;

   // predictor state
   logic [lps_pkg::ID_BITS-1:0]    job_id      [lps_pkg::STACK_DEPTH];
   logic [lps_pkg::BURST_BITS-1:0] job_left    [lps_pkg::STACK_DEPTH];
   logic [lps_pkg::BURST_BITS-1:0] job_burst   [lps_pkg::STACK_DEPTH];
   lps_pkg::time_type              job_arrival [lps_pkg::STACK_DEPTH];
   int                             job_count = 0;
   lps_pkg::time_type              now_tick = '0;

   lps_pkg::rsp_type pending_reports [$];
   lps_pkg::rsp_type oldest_report;
   int               fail_count = 0;
   int               cycle_count = 0;

   // typed reports are the ones readable straight off the tick count
   stim_row_type directed_rows [13] = '{
      '{'{lps_pkg::MODE_TICK,   8'h00, 16'h0000}, 1'b0, '0},
      '{'{lps_pkg::MODE_ARRIVE, 8'hff, 16'h0000}, 1'b1,
        '{lps_pkg::KIND_ZERO, 8'hff, 32'd0, 32'd0}},
      '{'{lps_pkg::MODE_ARRIVE, 8'h00, 16'h0001}, 1'b0, '0},
      '{'{lps_pkg::MODE_TICK,   8'h00, 16'h0000}, 1'b1,
        '{lps_pkg::KIND_DONE, 8'h00, 32'd1, 32'd0}},
      '{'{lps_pkg::MODE_ARRIVE, 8'h5a, 16'h0003}, 1'b0, '0},
      '{'{lps_pkg::MODE_ARRIVE, 8'h3c, 16'h0001}, 1'b0, '0},
      '{'{lps_pkg::MODE_TICK,   8'hff, 16'hffff}, 1'b1,
        '{lps_pkg::KIND_DONE, 8'h3c, 32'd1, 32'd0}},
      '{'{lps_pkg::MODE_TICK,   8'h00, 16'h0000}, 1'b0, '0},
      '{'{lps_pkg::MODE_TICK,   8'h00, 16'h0000}, 1'b0, '0},
      '{'{lps_pkg::MODE_TICK,   8'h00, 16'h0000}, 1'b0, '0},
      '{'{lps_pkg::MODE_ARRIVE, 8'h00, 16'h0000}, 1'b1,
        '{lps_pkg::KIND_ZERO, 8'h00, 32'd0, 32'd0}},
      '{'{lps_pkg::MODE_ARRIVE, 8'ha5, 16'hffff}, 1'b0, '0},
      '{'{lps_pkg::MODE_TICK,   8'h00, 16'h0000}, 1'b0, '0}
   };

   lifo_preemptive_scheduler_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #2 clock = ~clock;

   // one scheduler step; returns whether the beat yields a report
   function automatic logic schedule_step(input lps_pkg::req_type beat,
                                          output lps_pkg::rsp_type report);
      int                                top;
      logic [lps_pkg::OUT_TIME_BITS-1:0] turnaround;
      report = '0;
      schedule_step = 1'b0;
      if (beat.mode == lps_pkg::MODE_ARRIVE) begin
         report.proc_id_res = beat.proc_id;
         if (beat.burst == '0) begin
            report.kind = lps_pkg::KIND_ZERO;
            return 1'b1;
         end
         if (job_count >= lps_pkg::STACK_DEPTH) begin
            report.kind = lps_pkg::KIND_DROP;
            return 1'b1;
         end
         job_id[job_count]      = beat.proc_id;
         job_left[job_count]    = beat.burst;
         job_burst[job_count]   = beat.burst;
         job_arrival[job_count] = now_tick;
         job_count++;
         return 1'b0;
      end
      if (job_count > 0) begin
         top = job_count - 1;
         if (job_left[top] != '0) begin
            job_left[top] = job_left[top] - 1'b1;
         end
         if (job_left[top] == '0) begin
            turnaround = lps_pkg::OUT_TIME_BITS'(now_tick - job_arrival[top] + 1'b1);
            report.kind            = lps_pkg::KIND_DONE;
            report.proc_id_res     = job_id[top];
            report.turnaround_time = turnaround;
            report.wait_ticks      = turnaround - lps_pkg::OUT_TIME_BITS'(job_burst[top]);
            job_count = top;
            schedule_step = 1'b1;
         end
      end
      now_tick = now_tick + 1'b1;
   endfunction

   // offer one beat, hold it until taken, then record what it should produce
   task automatic send_beat(input lps_pkg::req_type beat, input logic typed,
                            input lps_pkg::rsp_type typed_report, input int idle_pct);
      lps_pkg::rsp_type predicted;
      logic             has_report;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      has_report = schedule_step(beat, predicted);
      if (typed) begin
         pending_reports.insert(pending_reports.size(), typed_report);
      end else if (has_report) begin
         pending_reports.insert(pending_reports.size(), predicted);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // results cannot be held off, so every strobe is taken on the spot
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected result: kind %0d id %0h", rsp_data.kind, rsp_data.proc_id_res);
            fail_count++;
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_data.kind !== oldest_report.kind) begin
               $error("kind: expected %0d, got %0d", oldest_report.kind, rsp_data.kind);
               fail_count++;
            end
            if (rsp_data.proc_id_res !== oldest_report.proc_id_res) begin
               $error("proc_id_res: expected %0h, got %0h",
                      oldest_report.proc_id_res, rsp_data.proc_id_res);
               fail_count++;
            end
            if (rsp_data.turnaround_time !== oldest_report.turnaround_time) begin
               $error("turnaround_time: expected %0d, got %0d",
                      oldest_report.turnaround_time, rsp_data.turnaround_time);
               fail_count++;
            end
            if (rsp_data.wait_ticks !== oldest_report.wait_ticks) begin
               $error("wait_ticks: expected %0d, got %0d",
                      oldest_report.wait_ticks, rsp_data.wait_ticks);
               fail_count++;
            end
         end
      end
   end

   initial begin
      lps_pkg::req_type beat;
      int               tick_pct;
      int               quiet_lo;
      int               pick;
      int               waited;
      tick_pct = 50;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].report, 21);
      end

      // a window of back-to-back beats somewhere in the random part
      quiet_lo = $urandom_range(200, 900);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // tick density per segment: low fills the stack, high drains it
         if (n % 60 == 0) begin
            tick_pct = 20 + 15 * $urandom_range(4);
         end
         beat.proc_id = lps_pkg::ID_BITS'($urandom);
         beat.burst   = lps_pkg::BURST_BITS'($urandom);
         if ($urandom_range(99) < tick_pct) begin
            beat.mode = lps_pkg::MODE_TICK;
         end else begin
            beat.mode = lps_pkg::MODE_ARRIVE;
            pick = $urandom_range(99);
            if (pick < 8) begin
               beat.burst = '0;
            end else if (job_count < lps_pkg::STACK_DEPTH) begin
               // short jobs so that they complete; full-range bursts only hit a full stack
               beat.burst = lps_pkg::BURST_BITS'($urandom_range(1, 6));
            end
         end
         send_beat(beat, 1'b0, '0, (n >= quiet_lo && n < quiet_lo + 300) ? 0 : 21);
      end
      start <= 1'b0;

      waited = 0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d expected results never arrived", pending_reports.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/lps_pkg.sv
hdl/lps_stack.sv
hdl/lps_sched.sv
hdl/lifo_preemptive_scheduler_core.sv
tb/sv/tb_lifo_preemptive_scheduler_core.sv
